@@ rtl/rfh_pkg.sv @@
// Package for the range filtered histogram core: command and reply codes,
// transfer payload structs, configuration indexes and reset values.
// No dependencies.
`default_nettype none

package rfh_pkg;

	localparam int BINS_DEFAULT        = 1024;
	localparam int COUNT_WIDTH_DEFAULT = 32;

	// reply queue depth, also the credit limit on replies queued or in flight
	localparam int RSP_FIFO_DEPTH = 4;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;

	localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

	localparam logic [30:0]        INPUT_MIN_RST  = 31'd0;
	localparam logic [30:0]        INPUT_MAX_RST  = 31'd1023;
	localparam logic signed [31:0] RESULT_MIN_RST = INT_MIN;
	localparam logic signed [31:0] RESULT_MAX_RST = INT_MAX;

	typedef enum logic [1:0] {
		CMD_SAMPLE       = 2'd0,
		CMD_MALFORMED    = 2'd1,
		CMD_READ_SUMMARY = 2'd2,
		CMD_READ_BIN     = 2'd3
	} cmd_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_INPUT_MIN  = 2'd0,
		CFG_INPUT_MAX  = 2'd1,
		CFG_RESULT_MIN = 2'd2,
		CFG_RESULT_MAX = 2'd3
	} cfg_index_t;

	localparam logic REPLY_SUMMARY = 1'b0;
	localparam logic REPLY_BIN     = 1'b1;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [31:0] code_value;
		logic signed [31:0] result_value;
		logic [9:0]         bin_index;
	} req_t;

	typedef struct packed {
		logic               reply_kind;
		logic [31:0]        total_samples;
		logic [31:0]        rejected_samples;
		logic [31:0]        malformed_records;
		logic signed [31:0] result_low;
		logic signed [31:0] result_high;
		logic signed [31:0] code_low;
		logic signed [31:0] code_high;
		logic [31:0]        bin_value;
	} rsp_t;

endpackage

`default_nettype wire

@@ rtl/rfh_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// Read during write to the same address returns the old contents.
// No dependencies.
`default_nettype none

module rfh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/range_filtered_histogram_core.sv @@
// Range filtered histogram core: top level. Uses rfh_pkg and rfh_ram.
// Holds the statistics registers, the bin RAM pipeline and the reply queue.
//
// Takes one request per cycle while req_ready is high. A request passes
// through s1 (range checks, statistics update, bin RAM read) and then s2
// (bin increment and write back); a reply enters the queue at the end of s2
// and is then offered on rsp. The gap between the bin read in s1 and the
// write in s2 is covered by forwarding, so samples to the same bin may
// follow each other in every cycle. Requests are held off while the replies
// queued plus the replies in flight already fill all RSP_FIFO_DEPTH entries.
// After reset the bin RAM is zeroed one entry per cycle, and req_ready stays
// low until the last entry is cleared; configuration writes are taken
// throughout.
`default_nettype none

module range_filtered_histogram_core #(
	parameter int BINS        = rfh_pkg::BINS_DEFAULT,
	parameter int COUNT_WIDTH = rfh_pkg::COUNT_WIDTH_DEFAULT
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             req_valid,
	output logic                                  req_ready,
	input  wire rfh_pkg::req_t                    req,
	output logic                                  rsp_valid,
	input  wire logic                             rsp_ready,
	output rfh_pkg::rsp_t                         rsp,
	input  wire logic                             cfg_we,
	input  wire logic [rfh_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [rfh_pkg::CFG_DATA_W-1:0]   cfg_data
);

	import rfh_pkg::*;

	localparam int ADDR_W  = (BINS > 1) ? $clog2(BINS) : 1;
	localparam int PTR_W   = $clog2(RSP_FIFO_DEPTH);
	localparam int CNT_W   = $clog2(RSP_FIFO_DEPTH + 1);

	// configuration
	logic [30:0]        input_min_q, input_max_q;
	logic signed [31:0] result_min_q, result_max_q;

	// statistics
	logic [COUNT_WIDTH-1:0] total_q, reject_q, malformed_q;
	logic signed [31:0]     res_low_q, res_high_q, code_low_q, code_high_q;

	// clearing pass
	logic              clr_q;
	logic [ADDR_W-1:0] clr_addr_q;

	// stage 1
	logic               v_s1, reply_s1;
	logic [1:0]         cmd_s1;
	logic signed [31:0] code_s1, result_s1;
	logic [9:0]         bin_index_s1;

	// stage 2
	logic                   hit_s2, reply_s2;
	logic [ADDR_W-1:0]      addr_s2;
	logic                   fwd_s2, oob_s2;
	logic [COUNT_WIDTH-1:0] fwd_data_s2;
	rsp_t                   rsp_s2;

	// reply queue
	rsp_t             fifo_q [RSP_FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] fifo_cnt_q;

	// stage 1 logic
	logic signed [32:0]     code_x, imin_x, imax_x, off;
	logic                   code_in, res_in, off_ok, sample_s1, hit_s1;
	logic [ADDR_W-1:0]      raddr;
	logic                   fwd_s1, oob_s1;
	rsp_t                   rsp_s1;

	// stage 2 logic
	logic [COUNT_WIDTH-1:0] ram_rdata, bin_cur, bin_inc;
	logic                   ram_we;
	logic [ADDR_W-1:0]      ram_waddr;
	logic [COUNT_WIDTH-1:0] ram_wdata;
	rsp_t                   rsp_push;

	logic [3:0] pending;
	logic       req_xfer, rsp_xfer, push;

	assign req_xfer  = req_valid && req_ready;
	assign rsp_xfer  = rsp_valid && rsp_ready;
	assign push      = reply_s2;
	assign pending   = 4'(fifo_cnt_q) + 4'(reply_s1) + 4'(reply_s2);
	assign req_ready = !clr_q && (pending < 4'(RSP_FIFO_DEPTH));

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_min_q  <= INPUT_MIN_RST;
			input_max_q  <= INPUT_MAX_RST;
			result_min_q <= RESULT_MIN_RST;
			result_max_q <= RESULT_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_INPUT_MIN:  input_min_q  <= cfg_data[30:0];
				CFG_INPUT_MAX:  input_max_q  <= cfg_data[30:0];
				CFG_RESULT_MIN: result_min_q <= $signed(cfg_data);
				CFG_RESULT_MAX: result_max_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// ---------------- stage 1 ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			reply_s1 <= 1'b0;
		end else begin
			v_s1     <= req_xfer;
			reply_s1 <= req_xfer && (req.cmd inside {CMD_READ_SUMMARY, CMD_READ_BIN});
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			cmd_s1       <= req.cmd;
			code_s1      <= req.code_value;
			result_s1    <= req.result_value;
			bin_index_s1 <= req.bin_index;
		end
	end

	always_comb begin
		code_x    = {code_s1[31], code_s1};
		imin_x    = $signed({2'b00, input_min_q});
		imax_x    = $signed({2'b00, input_max_q});
		code_in   = (code_x >= imin_x) && (code_x <= imax_x);
		res_in    = (result_s1 >= result_min_q) && (result_s1 <= result_max_q);
		off       = code_x - imin_x;
		off_ok    = !off[32] && (off < 33'(BINS));
		sample_s1 = v_s1 && (cmd_s1 == CMD_SAMPLE);
		hit_s1    = sample_s1 && code_in && res_in && off_ok;
		raddr     = (cmd_s1 == CMD_READ_BIN) ? ADDR_W'(bin_index_s1) : ADDR_W'(off);
		oob_s1    = 32'(bin_index_s1) >= 32'(BINS);
		// s2 writes this cycle; the RAM read would see the old value
		fwd_s1    = hit_s2 && (addr_s2 == raddr);

		rsp_s1 = '0;
		if (cmd_s1 == CMD_READ_BIN) begin
			rsp_s1.reply_kind = REPLY_BIN;
		end else begin
			rsp_s1.reply_kind        = REPLY_SUMMARY;
			rsp_s1.total_samples     = 32'(total_q);
			rsp_s1.rejected_samples  = 32'(reject_q);
			rsp_s1.malformed_records = 32'(malformed_q);
			rsp_s1.result_low        = res_low_q;
			rsp_s1.result_high       = res_high_q;
			rsp_s1.code_low          = code_low_q;
			rsp_s1.code_high         = code_high_q;
		end
	end

	// statistics update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			reject_q    <= '0;
			malformed_q <= '0;
			res_low_q   <= INT_MAX;
			res_high_q  <= INT_MIN;
			code_low_q  <= INT_MAX;
			code_high_q <= INT_MIN;
		end else begin
			if (sample_s1) begin
				if (total_q != '1) total_q <= total_q + 1'b1;
				if (code_s1 < code_low_q) code_low_q <= code_s1;
				if (code_s1 > code_high_q) code_high_q <= code_s1;
				if (code_in) begin
					if (result_s1 < res_low_q) res_low_q <= result_s1;
					if (result_s1 > res_high_q) res_high_q <= result_s1;
				end
				if (!hit_s1 && reject_q != '1) reject_q <= reject_q + 1'b1;
			end
			if (v_s1 && cmd_s1 == CMD_MALFORMED && malformed_q != '1) begin
				malformed_q <= malformed_q + 1'b1;
			end
		end
	end

	// ---------------- stage 2 ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s2   <= 1'b0;
			reply_s2 <= 1'b0;
		end else begin
			hit_s2   <= hit_s1;
			reply_s2 <= reply_s1;
		end
	end

	always_ff @(posedge clk) begin
		addr_s2     <= raddr;
		fwd_s2      <= fwd_s1;
		fwd_data_s2 <= bin_inc;
		oob_s2      <= oob_s1;
		rsp_s2      <= rsp_s1;
	end

	always_comb begin
		bin_cur = fwd_s2 ? fwd_data_s2 : ram_rdata;
		bin_inc = (bin_cur == '1) ? bin_cur : bin_cur + 1'b1;

		rsp_push = rsp_s2;
		if (rsp_s2.reply_kind == REPLY_BIN) begin
			rsp_push.bin_value = oob_s2 ? 32'd0 : 32'(bin_cur);
		end

		if (clr_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = hit_s2;
			ram_waddr = addr_s2;
			ram_wdata = bin_inc;
		end
	end

	rfh_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (BINS)
	) u_bin_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	// zero the bin RAM after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			if (clr_addr_q == ADDR_W'(BINS - 1)) begin
				clr_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// ---------------- reply queue ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rsp_xfer) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, rsp_xfer})
				2'b10:   fifo_cnt_q <= fifo_cnt_q + 1'b1;
				2'b01:   fifo_cnt_q <= fifo_cnt_q - 1'b1;
				default: fifo_cnt_q <= fifo_cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= rsp_push;
		end
	end

	assign rsp_valid = (fifo_cnt_q != '0);
	assign rsp       = fifo_q[rd_ptr_q];

endmodule

`default_nettype wire

@@ sim/tb_range_filtered_histogram_core.sv @@
// Self-checking testbench for range_filtered_histogram_core.
// Depends on rfh_pkg and the core RTL; a scoreboard class mirrors the
// histogram and statistics and checks every summary and bin reply.
`timescale 1ns / 100ps

module tb_range_filtered_histogram_core;
	import rfh_pkg::*;

	localparam int NUM_BINS = BINS_DEFAULT;

	class histogram_mirror;
		logic [30:0]        in_lo;
		logic [30:0]        in_hi;
		logic signed [31:0] res_lo;
		logic signed [31:0] res_hi;
		logic [31:0]        total_cnt;
		logic [31:0]        reject_cnt;
		logic [31:0]        malformed_cnt;
		logic signed [31:0] res_seen_lo;
		logic signed [31:0] res_seen_hi;
		logic signed [31:0] code_seen_lo;
		logic signed [31:0] code_seen_hi;
		logic [31:0]        bin_count [NUM_BINS];
		rsp_t               pending_replies [$];
		int                 error_count;

		function new();
			in_lo = INPUT_MIN_RST;
			in_hi = INPUT_MAX_RST;
			res_lo = RESULT_MIN_RST;
			res_hi = RESULT_MAX_RST;
			total_cnt = '0;
			reject_cnt = '0;
			malformed_cnt = '0;
			res_seen_lo = INT_MAX;
			res_seen_hi = INT_MIN;
			code_seen_lo = INT_MAX;
			code_seen_hi = INT_MIN;
			foreach (bin_count[i]) bin_count[i] = '0;
			error_count = 0;
		endfunction

		function logic [31:0] bump(logic [31:0] v);
			return (v == '1) ? v : v + 32'd1;
		endfunction

		function void apply_config(cfg_index_t idx, logic [31:0] data);
			case (idx)
				CFG_INPUT_MIN:  in_lo = data[30:0];
				CFG_INPUT_MAX:  in_hi = data[30:0];
				CFG_RESULT_MIN: res_lo = data;
				CFG_RESULT_MAX: res_hi = data;
				default: ;
			endcase
		endfunction

		function void note_request(req_t item);
			rsp_t   reply;
			longint code;
			longint off;
			reply = '0;
			case (cmd_t'(item.cmd))
				CMD_SAMPLE: begin
					code = item.code_value;
					total_cnt = bump(total_cnt);
					if (item.code_value < code_seen_lo) code_seen_lo = item.code_value;
					if (item.code_value > code_seen_hi) code_seen_hi = item.code_value;
					if (code < longint'(in_lo) || code > longint'(in_hi)) begin
						reject_cnt = bump(reject_cnt);
					end else begin
						if (item.result_value < res_seen_lo) res_seen_lo = item.result_value;
						if (item.result_value > res_seen_hi) res_seen_hi = item.result_value;
						off = code - longint'(in_lo);
						if (item.result_value < res_lo || item.result_value > res_hi) begin
							reject_cnt = bump(reject_cnt);
						end else if (off >= NUM_BINS) begin
							// in range, but past the last bin
							reject_cnt = bump(reject_cnt);
						end else begin
							bin_count[off] = bump(bin_count[off]);
						end
					end
				end
				CMD_MALFORMED: malformed_cnt = bump(malformed_cnt);
				CMD_READ_SUMMARY: begin
					reply.reply_kind = REPLY_SUMMARY;
					reply.total_samples = total_cnt;
					reply.rejected_samples = reject_cnt;
					reply.malformed_records = malformed_cnt;
					reply.result_low = res_seen_lo;
					reply.result_high = res_seen_hi;
					reply.code_low = code_seen_lo;
					reply.code_high = code_seen_hi;
					pending_replies.push_back(reply);
				end
				CMD_READ_BIN: begin
					reply.reply_kind = REPLY_BIN;
					reply.bin_value = (item.bin_index < NUM_BINS) ? bin_count[item.bin_index] : '0;
					pending_replies.push_back(reply);
				end
				default: ;
			endcase
		endfunction

		task report_mismatch(string msg);
			error_count++;
			$display("mismatch at %0t: %s", $realtime, msg);
		endtask

		task compare_field(string field, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report_mismatch($sformatf("%s got %h expected %h", field, got, want));
		endtask

		task check_reply(rsp_t got);
			rsp_t want;
			if (pending_replies.size() == 0) begin
				report_mismatch("reply with no request pending");
			end else begin
				want = pending_replies.pop_front();
				compare_field("reply_kind", 32'(got.reply_kind), 32'(want.reply_kind));
				compare_field("total_samples", got.total_samples, want.total_samples);
				compare_field("rejected_samples", got.rejected_samples, want.rejected_samples);
				compare_field("malformed_records", got.malformed_records,
					want.malformed_records);
				compare_field("result_low", got.result_low, want.result_low);
				compare_field("result_high", got.result_high, want.result_high);
				compare_field("code_low", got.code_low, want.code_low);
				compare_field("code_high", got.code_high, want.code_high);
				compare_field("bin_value", got.bin_value, want.bin_value);
			end
		endtask
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   req_valid = 1'b0;
	logic                   req_ready;
	req_t                   req = '0;
	logic                   rsp_valid;
	logic                   rsp_ready = 1'b0;
	rsp_t                   rsp;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	bit                     quiet_phase = 1'b0;
	bit                     hold_request = 1'b0;
	histogram_mirror        tracker;

	range_filtered_histogram_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("tb_range_filtered_histogram_core: FAIL");
		$finish;
	end

	// reply side: random stalls, long hold-offs on request
	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				rsp_ready <= 1'b0;
				hold_request = 1'b0;
				repeat (300) @(posedge clk);
			end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end else begin
				rsp_ready <= 1'b1;
				repeat (quiet_phase ? 1 : $urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) tracker.check_reply(rsp);
	end

	// request transfer; valid stays high on return so back-to-back items need no toggle
	task automatic send_req(req_t item);
		if (!quiet_phase && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		tracker.note_request(item);
	endtask

	task automatic write_register(cfg_index_t idx, logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		tracker.apply_config(idx, data);
	endtask

	// bit 31 of the input range words is don't-care, so it is randomized
	task automatic program_ranges(logic [30:0] imin, logic [30:0] imax,
			logic signed [31:0] rmin, logic signed [31:0] rmax);
		write_register(CFG_INPUT_MIN, {1'($urandom_range(0, 1)), imin});
		write_register(CFG_INPUT_MAX, {1'($urandom_range(0, 1)), imax});
		write_register(CFG_RESULT_MIN, rmin);
		write_register(CFG_RESULT_MAX, rmax);
		cfg_we <= 1'b0;
	endtask

	// samples leave no reply, so keep waiting after the last reply to let them drain
	task automatic settle_pipeline();
		req_valid <= 1'b0;
		while (tracker.pending_replies.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic req_t mk_req(cmd_t cmd, logic signed [31:0] code,
			logic signed [31:0] res, logic [9:0] idx);
		req_t item;
		item.cmd = cmd;
		item.code_value = code;
		item.result_value = res;
		item.bin_index = idx;
		return item;
	endfunction

	function automatic logic signed [31:0] make_code();
		longint lo;
		longint hi;
		lo = longint'(tracker.in_lo) - 20;
		if (tracker.in_hi >= tracker.in_lo)
			hi = (longint'(tracker.in_hi) < lo + 1120) ? longint'(tracker.in_hi) : lo + 1120;
		else
			hi = longint'(tracker.in_lo);
		hi = hi + 20;
		if ($urandom_range(0, 9) < 2) return $urandom;
		return 32'(lo + $urandom_range(0, 32'(hi - lo)));
	endfunction

	function automatic logic signed [31:0] make_result();
		longint rl;
		longint rh;
		rl = tracker.res_lo;
		rh = tracker.res_hi;
		if ($urandom_range(0, 9) < 3 || rh - rl > 100000 || rh < rl) return $urandom;
		return 32'(rl - 10 + $urandom_range(0, 32'(rh - rl + 20)));
	endfunction

	function automatic req_t make_request();
		req_t item;
		int   pick;
		int   span;
		item = mk_req(CMD_SAMPLE, $urandom, $urandom, 10'($urandom));
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			item.code_value = make_code();
			item.result_value = make_result();
		end else if (pick < 65) begin
			item.cmd = CMD_MALFORMED;
		end else if (pick < 80) begin
			item.cmd = CMD_READ_SUMMARY;
		end else begin
			item.cmd = CMD_READ_BIN;
			span = (tracker.in_hi >= tracker.in_lo) ? int'(tracker.in_hi - tracker.in_lo) : 0;
			if (span > NUM_BINS - 1 || span < 0) span = NUM_BINS - 1;
			if ($urandom_range(0, 9) < 7) item.bin_index = 10'($urandom_range(0, span));
		end
		return item;
	endfunction

	task automatic run_random(int count, int hold_at);
		for (int i = 0; i < count; i++) begin
			if (i == hold_at) hold_request = 1'b1;
			send_req(make_request());
		end
		settle_pipeline();
	endtask

	initial begin
		logic [30:0] base;
		tracker = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// default ranges: bin edges, negative and extreme codes, extreme results
		program_ranges(31'd0, 31'd1023, INT_MIN, INT_MAX);
		send_req(mk_req(CMD_SAMPLE, 32'sd0, INT_MIN, 10'd0));
		send_req(mk_req(CMD_SAMPLE, 32'sd1023, INT_MAX, 10'd0));
		send_req(mk_req(CMD_SAMPLE, 32'sd1023, 32'sd0, 10'd0));
		send_req(mk_req(CMD_SAMPLE, 32'sd1024, 32'sd5, 10'd0));
		send_req(mk_req(CMD_SAMPLE, -32'sd1, 32'sd7, 10'd0));
		send_req(mk_req(CMD_SAMPLE, INT_MIN, 32'sd0, 10'd0));
		send_req(mk_req(CMD_SAMPLE, INT_MAX, 32'sd0, 10'd0));
		send_req(mk_req(CMD_MALFORMED, 32'sd0, 32'sd0, 10'd0));
		send_req(mk_req(CMD_READ_SUMMARY, 32'sd0, 32'sd0, 10'd0));
		send_req(mk_req(CMD_READ_BIN, 32'sd0, 32'sd0, 10'd0));
		send_req(mk_req(CMD_READ_BIN, 32'sd0, 32'sd0, 10'd1023));
		send_req(mk_req(CMD_READ_BIN, 32'sd0, 32'sd0, 10'd512));
		settle_pipeline();

		// range wider than the bins, narrow result window
		program_ranges(31'd100, 31'd2000, -32'sd50, 32'sd50);
		send_req(mk_req(CMD_SAMPLE, 32'sd1200, 32'sd0, 10'd0));
		send_req(mk_req(CMD_SAMPLE, 32'sd100, -32'sd50, 10'd0));
		send_req(mk_req(CMD_SAMPLE, 32'sd1123, 32'sd50, 10'd0));
		send_req(mk_req(CMD_SAMPLE, 32'sd150, 32'sd51, 10'd0));
		send_req(mk_req(CMD_SAMPLE, 32'sd99, -32'sd51, 10'd0));
		send_req(mk_req(CMD_READ_SUMMARY, 32'sd0, 32'sd0, 10'd0));
		send_req(mk_req(CMD_READ_BIN, 32'sd0, 32'sd0, 10'd0));
		send_req(mk_req(CMD_READ_BIN, 32'sd0, 32'sd0, 10'd1023));
		settle_pipeline();

		// inverted input range rejects everything
		program_ranges(31'd500, 31'd400, INT_MIN, INT_MAX);
		send_req(mk_req(CMD_SAMPLE, 32'sd450, 32'sd0, 10'd0));
		send_req(mk_req(CMD_READ_SUMMARY, 32'sd0, 32'sd0, 10'd0));
		settle_pipeline();

		// single-code range at the top of the register span
		program_ranges(31'h7fff_ffff, 31'h7fff_ffff, INT_MIN, INT_MAX);
		send_req(mk_req(CMD_SAMPLE, INT_MAX, 32'sd3, 10'd0));
		send_req(mk_req(CMD_READ_BIN, 32'sd0, 32'sd0, 10'd0));
		send_req(mk_req(CMD_READ_SUMMARY, 32'sd0, 32'sd0, 10'd0));
		settle_pipeline();

		program_ranges(31'd0, 31'd1023, INT_MIN, INT_MAX);
		run_random(360, 150);

		base = 31'($urandom_range(0, 5000));
		program_ranges(base, base + 31'($urandom_range(0, 1500)),
			-32'sd1 * $urandom_range(0, 1000), 32'($urandom_range(0, 1000)));
		run_random(340, -1);

		base = 31'($urandom_range(1000, 3000));
		program_ranges(base, base - 31'($urandom_range(1, 500)), INT_MIN, INT_MAX);
		run_random(300, -1);

		base = 31'($urandom);
		program_ranges(31'd0, 31'h7fff_ffff, $signed(32'(base)), $signed(32'(base)));
		run_random(340, 100);

		quiet_phase = 1'b1;
		program_ranges(31'h7fff_ffff - 31'd600, 31'h7fff_ffff, -32'sd100000, 32'sd100000);
		run_random(360, -1);

		repeat (10) @(posedge clk);
		if (tracker.error_count == 0 && tracker.pending_replies.size() == 0)
			$display("tb_range_filtered_histogram_core: PASS");
		else
			$display("tb_range_filtered_histogram_core: FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/rfh_pkg.sv
rtl/rfh_ram.sv
rtl/range_filtered_histogram_core.sv
sim/tb_range_filtered_histogram_core.sv
